@@ hw/rtl/sud_pkg.sv @@
// ----------------------------------------------------------------------------
// sud_pkg: shared types and constants of the integer divider
// Holds the operand width and the word that travels through the pipeline.
// ----------------------------------------------------------------------------
package sud_pkg;

   // Operand and result width in bits.
   localparam int DATA_WIDTH = 32;

   // Division modes carried by the mode bit of a request word.
   localparam logic MODE_UNSIGNED = 1'b0;
   localparam logic MODE_SIGNED   = 1'b1;

   // Working word of one pipeline stage of the restoring divider.
   // quo_div starts as the dividend magnitude; each stage shifts one dividend
   // bit out at the top and one quotient bit in at the bottom.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;      // partial remainder
      logic [DATA_WIDTH-1:0] quo_div;  // remaining dividend bits and quotient bits
      logic [DATA_WIDTH-1:0] dsr_mag;  // divisor magnitude
      logic                  rem_neg;  // negate the remainder at the end
      logic                  quo_neg;  // negate the quotient at the end
      logic                  div_zero; // divisor was zero
   } div_stage_type;

endpackage

@@ hw/rtl/sud_req_if.sv @@
// ----------------------------------------------------------------------------
// sud_req_if: request channel of the integer divider
// Carries one division request word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sud_req_if import sud_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] dividend;
   logic [DATA_WIDTH-1:0] divisor;
   logic                  mode;

   modport source (output valid, output dividend, output divisor, output mode,
                   input ready);
   modport sink   (input valid, input dividend, input divisor, input mode,
                   output ready);

endinterface

@@ hw/rtl/sud_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sud_rsp_if: response channel of the integer divider
// Carries one quotient/remainder word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sud_rsp_if import sud_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] quotient;
   logic [DATA_WIDTH-1:0] remainder;
   logic                  div_by_zero;

   modport source (output valid, output quotient, output remainder,
                   output div_by_zero, input ready);
   modport sink   (input valid, input quotient, input remainder,
                   input div_by_zero, output ready);

endinterface

@@ hw/rtl/sud_div_stage.sv @@
// ----------------------------------------------------------------------------
// sud_div_stage: one registered step of the restoring divider
// Shifts one dividend bit into the partial remainder, tries a subtraction of
// the divisor and records one quotient bit.
// ----------------------------------------------------------------------------
module sud_div_stage import sud_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  div_stage_type in_stage,
   output logic          out_valid,
   output div_stage_type out_stage
);

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;
   div_stage_type         stage_in;
   div_stage_type         stage_ff;
   logic                  valid_ff;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {in_stage.rem, in_stage.quo_div[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, in_stage.dsr_mag};
      fits    = ~diff[DATA_WIDTH+1];

      stage_in         = in_stage;
      stage_in.rem     = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      stage_in.quo_div = {in_stage.quo_div[DATA_WIDTH-2:0], fits};
   end

   // Stage register; the whole pipeline holds while the output is blocked.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ hw/rtl/signed_unsigned_int_divider.sv @@
// ----------------------------------------------------------------------------
// signed_unsigned_int_divider: pipelined 32-bit signed and unsigned divider
// Returns quotient, remainder and a divide-by-zero flag for each request.
// ----------------------------------------------------------------------------
// The divider accepts one request word per clock cycle while the pipeline
// advances and returns one response word per request, in order. A request
// passes an input register that takes the operand magnitudes, one
// restoring-division stage per quotient bit, and an output register that
// takes the sign-restored results. The whole pipeline advances together; it
// halts only while the output register holds a word that the sink does not
// take, and then req_chan.ready is low. In signed mode the quotient truncates
// toward zero and the remainder takes the sign of the dividend; the most
// negative value divided by minus one wraps to itself with a zero remainder.
// A zero divisor gives an all-ones quotient, the dividend as remainder and
// div_by_zero set, in either mode.
// ----------------------------------------------------------------------------
module signed_unsigned_int_divider import sud_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sud_req_if.sink   req_chan,
   sud_rsp_if.source rsp_chan
);

   logic                  advance;
   logic                  dsr_zero;
   logic                  dvd_neg;
   logic                  dsr_neg;
   div_stage_type         pre_in;
   div_stage_type         pre_ff;
   logic                  pre_valid_ff;
   logic                  step_valid [DATA_WIDTH+1];
   div_stage_type         step_stage [DATA_WIDTH+1];
   div_stage_type         last_stage;
   logic [DATA_WIDTH-1:0] quotient_in;
   logic [DATA_WIDTH-1:0] remainder_in;
   logic [DATA_WIDTH-1:0] quotient_ff;
   logic [DATA_WIDTH-1:0] remainder_ff;
   logic                  div_zero_ff;
   logic                  rsp_valid_ff;

   // The pipeline moves whenever the output register is free or being read.
   assign advance        = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = advance;

   // Operand magnitudes and sign handling. A zero divisor keeps the dividend
   // unsigned so that the steps leave it unchanged as the remainder.
   always_comb begin
      dsr_zero = (req_chan.divisor == '0);
      dvd_neg  = (req_chan.mode == MODE_SIGNED) & req_chan.dividend[DATA_WIDTH-1]
                 & ~dsr_zero;
      dsr_neg  = (req_chan.mode == MODE_SIGNED) & req_chan.divisor[DATA_WIDTH-1];

      pre_in.rem      = '0;
      pre_in.quo_div  = dvd_neg ? (~req_chan.dividend + DATA_WIDTH'(1))
                                : req_chan.dividend;
      pre_in.dsr_mag  = dsr_neg ? (~req_chan.divisor + DATA_WIDTH'(1))
                                : req_chan.divisor;
      pre_in.rem_neg  = dvd_neg;
      pre_in.quo_neg  = dvd_neg ^ dsr_neg;
      pre_in.div_zero = dsr_zero;
   end

   // Input stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (advance) begin
         pre_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_ff <= pre_in;
      end
   end

   assign step_valid[0] = pre_valid_ff;
   assign step_stage[0] = pre_ff;

   // One restoring-division stage per quotient bit, most significant first.
   for (genvar gi = 0; gi < DATA_WIDTH; gi++) begin : g_step
      sud_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (step_valid[gi]),
         .in_stage  (step_stage[gi]),
         .out_valid (step_valid[gi+1]),
         .out_stage (step_stage[gi+1])
      );
   end

   // Sign restoration of quotient and remainder.
   always_comb begin
      last_stage   = step_stage[DATA_WIDTH];
      quotient_in  = last_stage.quo_neg ? (~last_stage.quo_div + DATA_WIDTH'(1))
                                        : last_stage.quo_div;
      remainder_in = last_stage.rem_neg ? (~last_stage.rem + DATA_WIDTH'(1))
                                        : last_stage.rem;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_valid[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff  <= quotient_in;
         remainder_ff <= remainder_in;
         div_zero_ff  <= last_stage.div_zero;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.quotient    = quotient_ff;
   assign rsp_chan.remainder   = remainder_ff;
   assign rsp_chan.div_by_zero = div_zero_ff;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the signed and unsigned integer divider
// Runs a table of corner-case divisions, then about 1200 random ones with
// random idling on both channels. The bench also holds the response channel
// off long enough to fill the pipeline, and once waits for the pipeline to
// drain. Every response word is checked against a local division model.
// ----------------------------------------------------------------------------
module testbench import sud_pkg::*; ();

   typedef logic [DATA_WIDTH-1:0] word_type;

   // One response word: what the divider returns for one request.
   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     div_by_zero;
   } quo_rem_type;

   // One row of the corner-case table; known holds a hand-written answer.
   typedef struct packed {
      word_type    dividend;
      word_type    divisor;
      logic        mode;
      logic        has_known;
      quo_rem_type known;
   } corner_row_type;

   localparam word_type W_ZERO = '0;
   localparam word_type W_ONES = '1;
   localparam word_type W_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam word_type W_MAX  = ~W_MIN;

   localparam int NUM_CORNERS   = 25;
   localparam int NUM_RANDOM    = 1200;
   localparam int CALM_TAIL     = 150;
   localparam int HOLD_AT_ITEM  = 300;
   localparam int HOLD_BURST    = 80;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_AT_ITEM = 600;
   localparam int DRAIN_CYCLES  = 2 * (DATA_WIDTH + 2);
   localparam int CYCLE_LIMIT   = 100000;
   localparam int MAX_REPORTS   = 10;

   // Corner cases: zero divisor, minimum over minus one, extremes, signs.
   localparam corner_row_type CORNERS [0:NUM_CORNERS-1] = '{
      '{W_ZERO, W_ZERO, MODE_UNSIGNED, 1'b1, '{W_ONES, W_ZERO, 1'b1}},
      '{32'h1234_5678, W_ZERO, MODE_SIGNED, 1'b1, '{W_ONES, 32'h1234_5678, 1'b1}},
      '{W_MIN, W_ZERO, MODE_SIGNED, 1'b1, '{W_ONES, W_MIN, 1'b1}},
      '{W_MIN, W_ONES, MODE_SIGNED, 1'b1, '{W_MIN, W_ZERO, 1'b0}},
      '{W_MIN, W_ONES, MODE_UNSIGNED, 1'b1, '{W_ZERO, W_MIN, 1'b0}},
      '{W_ONES, 32'h1, MODE_UNSIGNED, 1'b1, '{W_ONES, W_ZERO, 1'b0}},
      '{W_ONES, W_ONES, MODE_UNSIGNED, 1'b1, '{32'h1, W_ZERO, 1'b0}},
      '{W_ONES, W_ONES, MODE_SIGNED, 1'b1, '{32'h1, W_ZERO, 1'b0}},
      '{W_MAX, W_MIN, MODE_SIGNED, 1'b1, '{W_ZERO, W_MAX, 1'b0}},
      '{W_MIN, W_MIN, MODE_SIGNED, 1'b1, '{32'h1, W_ZERO, 1'b0}},
      '{W_MAX, 32'h1, MODE_SIGNED, 1'b1, '{W_MAX, W_ZERO, 1'b0}},
      '{W_ZERO, W_ONES, MODE_SIGNED, 1'b1, '{W_ZERO, W_ZERO, 1'b0}},
      '{W_ZERO, 32'h1, MODE_UNSIGNED, 1'b1, '{W_ZERO, W_ZERO, 1'b0}},
      '{32'hFFFF_FFF9, 32'h2, MODE_SIGNED, 1'b0, '0},
      '{32'h7, 32'hFFFF_FFFE, MODE_SIGNED, 1'b0, '0},
      '{32'hFFFF_FFF9, 32'hFFFF_FFFE, MODE_SIGNED, 1'b0, '0},
      '{32'hFFFF_FFF9, 32'h2, MODE_UNSIGNED, 1'b0, '0},
      '{W_MIN, 32'h2, MODE_SIGNED, 1'b0, '0},
      '{W_MIN, 32'h3, MODE_SIGNED, 1'b0, '0},
      '{W_MAX, W_MAX, MODE_UNSIGNED, 1'b0, '0},
      '{32'h1, W_ONES, MODE_UNSIGNED, 1'b0, '0},
      '{32'h1, W_ONES, MODE_SIGNED, 1'b0, '0},
      '{32'hDEAD_BEEF, 32'h0000_1234, MODE_UNSIGNED, 1'b0, '0},
      '{32'hDEAD_BEEF, 32'h0000_1234, MODE_SIGNED, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, MODE_SIGNED, 1'b0, '0}
   };

   logic clock;
   logic reset;

   sud_req_if req_chan ();
   sud_rsp_if rsp_chan ();

   signed_unsigned_int_divider u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Answers still owed by the divider, oldest first.
   quo_rem_type quotient_queue [$];

   int  fail_count    = 0;
   int  cycle_count   = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  signed_sent   = 0;
   int  zero_div_sent = 0;
   int  burst_left    = 0;
   bit  calm          = 1'b0;
   bit  hold_start    = 1'b0;

   // Clock generation.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Guard against a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d answers outstanding", cycle_count,
                  quotient_queue.size());
         $display("** signed_unsigned_int_divider: FAILED **");
         $finish;
      end
   end

   // Truncating division at the operand width, with the divider's rules for
   // a zero divisor and for the most negative value over minus one.
   function automatic quo_rem_type divide_word(word_type dividend, word_type divisor,
                                               logic mode);
      quo_rem_type answer;
      logic        dnd_neg;
      logic        dsr_neg;
      word_type    dnd_mag;
      word_type    dsr_mag;
      word_type    mag_quo;
      word_type    mag_rem;
      answer.div_by_zero = 1'b0;
      if (divisor == W_ZERO) begin
         answer.quotient    = W_ONES;
         answer.remainder   = dividend;
         answer.div_by_zero = 1'b1;
      end else if (mode == MODE_UNSIGNED) begin
         answer.quotient  = dividend / divisor;
         answer.remainder = dividend % divisor;
      end else begin
         // The magnitude of the minimum value wraps to itself, read unsigned.
         dnd_neg = dividend[DATA_WIDTH-1];
         dsr_neg = divisor[DATA_WIDTH-1];
         dnd_mag = dnd_neg ? W_ZERO - dividend : dividend;
         dsr_mag = dsr_neg ? W_ZERO - divisor : divisor;
         mag_quo = dnd_mag / dsr_mag;
         mag_rem = dnd_mag % dsr_mag;
         answer.quotient  = (dnd_neg != dsr_neg) ? W_ZERO - mag_quo : mag_quo;
         answer.remainder = dnd_neg ? W_ZERO - mag_rem : mag_rem;
      end
      return answer;
   endfunction

   // Operand mix: full-range patterns, extremes, small values of either sign,
   // shifted patterns and powers of two.
   function automatic word_type pick_operand();
      word_type value;
      value = word_type'($urandom());
      case ($urandom_range(0, 9))
         4: begin
            case ($urandom_range(0, 5))
               0: value = W_ZERO;
               1: value = word_type'(1);
               2: value = W_ONES;
               3: value = W_MIN;
               4: value = W_MAX;
               default: value = W_MIN + word_type'(1);
            endcase
         end
         5, 6: value = word_type'($urandom_range(0, 255));
         7: value = value >> $urandom_range(0, DATA_WIDTH - 1);
         8: value = W_ZERO - word_type'($urandom_range(0, 255));
         9: value = word_type'(1) << $urandom_range(0, DATA_WIDTH - 1);
         default: ;
      endcase
      return value;
   endfunction

   // Report one failure; only the first few are printed.
   task automatic report_failure(string what, word_type want, word_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("Mismatch at cycle %0d: %s expected %h, got %h", cycle_count, what,
                  want, got);
      end
   endtask

   // Random short idle burst on the request side.
   task automatic idle_request();
      if (!calm && burst_left == 0 && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Offer one request word and wait until it is taken; queue its answer.
   task automatic send_word(word_type dividend, word_type divisor, logic mode,
                            logic has_known, quo_rem_type known);
      req_chan.valid    <= 1'b1;
      req_chan.dividend <= dividend;
      req_chan.divisor  <= divisor;
      req_chan.mode     <= mode;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      quotient_queue.push_back(has_known ? known : divide_word(dividend, divisor, mode));
      words_sent++;
      if (mode == MODE_SIGNED) signed_sent++;
      if (divisor == W_ZERO) zero_div_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // Stop offering and wait until every owed answer has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (quotient_queue.size() > 0) @(posedge clock);
   endtask

   // Response side: check each accepted word and pick the next ready value.
   initial begin : response_side
      int          stall_left;
      int          hold_left;
      logic        next_ready;
      quo_rem_type want;
      stall_left = 0;
      hold_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (quotient_queue.size() == 0) begin
               report_failure("unexpected word, quotient", W_ZERO, rsp_chan.quotient);
            end else begin
               want = quotient_queue.pop_front();
               words_checked++;
               if (rsp_chan.quotient !== want.quotient)
                  report_failure("quotient", want.quotient, rsp_chan.quotient);
               if (rsp_chan.remainder !== want.remainder)
                  report_failure("remainder", want.remainder, rsp_chan.remainder);
               if (rsp_chan.div_by_zero !== want.div_by_zero)
                  report_failure("div_by_zero", word_type'(want.div_by_zero),
                                 word_type'(rsp_chan.div_by_zero));
            end
         end
         // Long hold-off first, then short random stalls.
         if (reset) begin
            next_ready = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // Request side and end of run.
   initial begin : request_side
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.dividend <= W_ZERO;
      req_chan.divisor  <= W_ZERO;
      req_chan.mode     <= MODE_UNSIGNED;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Corner-case table.
      for (int row = 0; row < NUM_CORNERS; row++) begin
         idle_request();
         send_word(CORNERS[row].dividend, CORNERS[row].divisor, CORNERS[row].mode,
                   CORNERS[row].has_known, CORNERS[row].known);
      end
      wait_drained();

      // Random divisions, with a long response hold-off, a full drain, and a
      // final stretch with no idling at all.
      for (int item = 0; item < NUM_RANDOM; item++) begin
         if (item == HOLD_AT_ITEM) begin
            hold_start = 1'b1;
            burst_left = HOLD_BURST;
         end
         if (item == DRAIN_AT_ITEM) wait_drained();
         if (item == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
         idle_request();
         send_word(pick_operand(), pick_operand(), logic'($urandom_range(0, 1)), 1'b0, '0);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d divisions (%0d signed, %0d by zero) in %0d cycles.",
               words_checked, words_sent, signed_sent, zero_div_sent, cycle_count);
      $display("Included a %0d-cycle response hold-off and %0d failures.", HOLD_CYCLES,
               fail_count);
      if (fail_count == 0) begin
         $display("** signed_unsigned_int_divider: PASSED **");
      end else begin
         $display("** signed_unsigned_int_divider: FAILED **");
      end
      $finish;
   end

endmodule

@@ signed_unsigned_int_divider.f @@
hw/rtl/sud_pkg.sv
hw/rtl/sud_req_if.sv
hw/rtl/sud_rsp_if.sv
hw/rtl/sud_div_stage.sv
hw/rtl/signed_unsigned_int_divider.sv
test/testbench.sv
